[hdl/qph_pkg.sv]
// Shared types, sizes and codes of the quadratic probing hash table.
package qph_pkg;

   // Slot count. Slot arithmetic wraps by masking, so it must be a power of two.
   localparam int unsigned TABLE_SLOTS = 256;
   localparam int unsigned IDX_W       = $clog2(TABLE_SLOTS);
   localparam int unsigned PROBE_LIMIT = TABLE_SLOTS / 2;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_LOOKUP = 2'd2;

   typedef logic [IDX_W-1:0] slot_idx_type;

   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_INSERT,
      OP_LOOKUP,
      OP_NONE
   } op_type;

   typedef enum logic {
      BK_IDLE,
      BK_PROBE
   } back_state_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] key_id;
      logic [31:0] key_hash;
      logic [63:0] value_word;
      logic [3:0]  value_tag;
   } req_item_type;

   typedef struct packed {
      logic        status;
      logic        found;
      logic [63:0] found_value;
      logic [3:0]  found_tag;
   } rsp_item_type;

   // A classified request as it waits in the queue.
   typedef struct packed {
      op_type       op;
      logic [31:0]  key_id;
      slot_idx_type home;
      logic [63:0]  value_word;
      logic [3:0]   value_tag;
   } job_type;

   typedef struct packed {
      logic [31:0] key_id;
      logic [63:0] value_word;
      logic [3:0]  value_tag;
   } slot_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

[hdl/qph_front.sv]
// Front end: takes requests, decodes the request type and the home slot.
module qph_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  qph_pkg::req_item_type req_data,
   input  qph_pkg::q_status_type q_status,
   output logic                 push,
   output qph_pkg::job_type     push_job
);
   import qph_pkg::*;

   logic    front_vld_ff;
   logic    front_vld_in;
   job_type job_ff;
   job_type job_in;
   job_type decoded;
   logic    accept;

   always_comb begin
      decoded            = '0;
      decoded.key_id     = req_data.key_id;
      decoded.home       = req_data.key_hash[IDX_W-1:0];
      decoded.value_word = req_data.value_word;
      decoded.value_tag  = req_data.value_tag;
      case (req_data.req_type)
         REQ_CLEAR:  decoded.op = OP_CLEAR;
         REQ_INSERT: decoded.op = OP_INSERT;
         REQ_LOOKUP: decoded.op = OP_LOOKUP;
         default:    decoded.op = OP_NONE;
      endcase
   end

   // The held request moves on whenever the queue has room.
   assign push   = front_vld_ff && !q_status.full;
   assign busy   = front_vld_ff && q_status.full;
   assign accept = start && !busy;

   assign front_vld_in = accept || (front_vld_ff && !push);
   assign job_in       = accept ? decoded : job_ff;
   assign push_job     = job_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_vld_ff <= 1'b0;
      end else begin
         front_vld_ff <= front_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

endmodule

[hdl/qph_queue.sv]
// Short first-in first-out queue of decoded jobs between front and back end.
module qph_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  qph_pkg::job_type      push_job,
   input  logic                  pop,
   output qph_pkg::job_type      head_job,
   output qph_pkg::q_status_type q_status
);
   import qph_pkg::*;

   job_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff;
   logic [QCNT_W-1:0]  count_in;
   logic               do_push;
   logic               do_pop;

   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head_job       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[hdl/qph_back.sv]
// Back end: walks the quadratic probe sequence over the slot store and answers.
module qph_back (
   input  logic                  clock,
   input  logic                  reset,
   input  qph_pkg::q_status_type q_status,
   input  qph_pkg::job_type      head_job,
   output logic                  pop,
   output logic                  rsp_strobe,
   output qph_pkg::rsp_item_type rsp_data
);
   import qph_pkg::*;

   back_state_type state_ff;
   back_state_type state_in;
   job_type        job_ff;
   job_type        job_in;
   slot_idx_type   step_ff;
   slot_idx_type   step_in;
   slot_idx_type   c_ff;
   slot_idx_type   c_in;
   slot_idx_type   sq_ff;
   slot_idx_type   sq_in;
   logic           issue_ff;
   logic           issue_in;
   logic           chk_vld_ff;
   logic           chk_vld_in;
   logic           chk_used_ff;
   logic           chk_used_in;
   logic           chk_last_ff;
   logic           chk_last_in;
   logic [TABLE_SLOTS-1:0] used_ff;
   logic [TABLE_SLOTS-1:0] used_in;
   logic           rsp_strobe_ff;
   logic           rsp_strobe_in;
   rsp_item_type   rsp_ff;
   rsp_item_type   rsp_in;

   slot_entry_type slot_mem [TABLE_SLOTS];
   slot_entry_type rd_data_ff;

   slot_idx_type   pos;
   logic           pos_used;
   logic           last;
   logic           key_hit;
   logic           finish;
   logic           advance;
   logic           issue;
   logic           wr_en;
   logic           clr_all;
   rsp_item_type   fin_rsp;

   // Even probes add the square, odd probes subtract it; the index width wraps.
   assign pos      = step_ff[0] ? (job_ff.home - sq_ff) : (job_ff.home + sq_ff);
   assign pos_used = used_ff[pos];
   assign last     = (step_ff == IDX_W'(PROBE_LIMIT));
   assign key_hit  = (rd_data_ff.key_id == job_ff.key_id);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:  if (!q_status.empty) state_in = BK_PROBE;
         BK_PROBE: if (finish) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop     = 1'b0;
      finish  = 1'b0;
      advance = 1'b0;
      issue   = 1'b0;
      wr_en   = 1'b0;
      clr_all = 1'b0;
      fin_rsp = '0;
      case (state_ff)
         BK_IDLE: begin
            pop = !q_status.empty;
         end
         BK_PROBE: begin
            case (job_ff.op)
               OP_CLEAR: begin
                  clr_all = 1'b1;
                  finish  = 1'b1;
               end
               OP_INSERT: begin
                  if (!pos_used) begin
                     wr_en  = 1'b1;
                     finish = 1'b1;
                  end else if (last) begin
                     finish         = 1'b1;
                     fin_rsp.status = 1'b1;
                  end else begin
                     advance = 1'b1;
                  end
               end
               OP_LOOKUP: begin
                  // Reads are issued one per cycle and each is checked in the cycle after.
                  if (chk_vld_ff) begin
                     if (!chk_used_ff) begin
                        finish = 1'b1;
                     end else if (key_hit) begin
                        finish              = 1'b1;
                        fin_rsp.found       = 1'b1;
                        fin_rsp.found_value = rd_data_ff.value_word;
                        fin_rsp.found_tag   = rd_data_ff.value_tag;
                     end else if (chk_last_ff) begin
                        finish = 1'b1;
                     end
                  end
                  issue   = issue_ff && !finish;
                  advance = issue && !last;
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
         end
         default: ;
      endcase
   end

   always_comb begin
      job_in      = job_ff;
      step_in     = step_ff;
      c_in        = c_ff;
      sq_in       = sq_ff;
      issue_in    = issue_ff;
      chk_vld_in  = issue;
      chk_used_in = pos_used;
      chk_last_in = last;
      used_in     = used_ff;
      if (pop) begin
         job_in   = head_job;
         step_in  = '0;
         c_in     = '0;
         sq_in    = '0;
         issue_in = 1'b1;
      end else begin
         if (advance) begin
            step_in = step_ff + IDX_W'(1);
            if (step_ff[0]) begin
               c_in  = c_ff + IDX_W'(1);
               sq_in = sq_ff + {c_ff[IDX_W-2:0], 1'b1};
            end
         end
         if (issue && last) begin
            issue_in = 1'b0;
         end
      end
      if (clr_all) begin
         used_in = '0;
      end else if (wr_en) begin
         used_in[pos] = 1'b1;
      end
      rsp_strobe_in = finish;
      rsp_in        = finish ? fin_rsp : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         issue_ff      <= 1'b0;
         chk_vld_ff    <= 1'b0;
         used_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_ff      <= issue_in;
         chk_vld_ff    <= chk_vld_in;
         used_ff       <= used_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      step_ff     <= step_in;
      c_ff        <= c_in;
      sq_ff       <= sq_in;
      chk_used_ff <= chk_used_in;
      chk_last_ff <= chk_last_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[pos] <= '{key_id: job_ff.key_id, value_word: job_ff.value_word,
                            value_tag: job_ff.value_tag};
      end
      rd_data_ff <= slot_mem[pos];
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

[hdl/quadratic_probe_hash_table_top.sv]
// Insert and lookup visit the home slot and up to 128 further probes at 256 slots.
// The back end works one request at a time and takes a new one only once the last has
// finished; up to three further requests wait in front of it.
// The receiver cannot stall: every result is shown for exactly one cycle on rsp_strobe.
// Synchronous reset empties the queue and marks every slot empty; slot contents are not reset.
module quadratic_probe_hash_table_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  qph_pkg::req_item_type req_data,
   output logic                  rsp_strobe,
   output qph_pkg::rsp_item_type rsp_data
);
   import qph_pkg::*;

   // The front end holds one request and pushes it into the queue when there is room.
   // A transfer takes place whenever start is high and busy is low.
   logic         push;
   job_type      push_job;
   logic         pop;
   job_type      head_job;
   q_status_type q_status;

   qph_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   // The queue decouples request intake from the probe engine.
   qph_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   // The back end owns the slot store. Insert checks one occupancy bit per cycle; lookup
   // streams slot reads one per cycle and compares each key in the cycle after its read.
   // Clear empties every slot at once through the occupancy bits.
   qph_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

[hdl/qph_checker.sv]
// Port-level checks on the hash table top level, bound to it.
module qph_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input qph_pkg::req_item_type req_data,
   input logic                  rsp_strobe,
   input qph_pkg::rsp_item_type rsp_data
);
   import qph_pkg::*;

   // Every request passes through the idle state, so results are never adjacent.
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results in consecutive cycles");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.found) |->
         (rsp_data.found_value == '0 && rsp_data.found_tag == '0))
      else $error("payload on a result without a match");

   a_status_found: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_data.status && rsp_data.found))
      else $error("full status and match in one result");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_strobe && !busy))
      else $error("activity right after reset");

endmodule

bind quadratic_probe_hash_table_top qph_checker u_qph_checker (.*);

[tb/sv/testbench.sv]
// Self-checking testbench of the quadratic probing hash table: random and directed requests.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import qph_pkg::*;

   // The package names three request codes; the fourth gets an all-zero answer and no table change.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // The slowest correct run has every request waiting out the longest sender gap
   // plus the deepest probe. The limit is several times that over all requests.
   localparam int unsigned CYCLE_LIMIT = 1_500_000;
   localparam int unsigned RANDOM_ITEMS = 750;
   localparam int unsigned DRAIN_CYCLES = 150;
   localparam int unsigned MAX_REPORTS = 100;

   // One queued request together with the idle cycles that precede it and a flag
   // that holds it back until every answer so far has come out.
   typedef struct {
      req_item_type item;
      int unsigned  gap;
      bit           drain;
   } queued_req_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req_data = '0;
   logic         rsp_strobe;
   rsp_item_type rsp_data;

   queued_req_type requests_waiting[$];
   rsp_item_type   answers_due[$];

   // Our own image of the table. Keys, values and tags are only read where the
   // used bit is set, exactly as in the block.
   bit            tbl_used[TABLE_SLOTS];
   logic [31:0]   tbl_key[TABLE_SLOTS];
   logic [63:0]   tbl_value[TABLE_SLOTS];
   logic [3:0]    tbl_tag[TABLE_SLOTS];

   int unsigned   error_count = 0;
   int unsigned   cycle_count = 0;
   int unsigned   sent_count = 0;
   int unsigned   heard_count = 0;
   int unsigned   gap_wait = 0;
   int unsigned   counted_items = 0;
   bit            quiet_mode = 1'b0;
   bit            drain_next = 1'b0;

   quadratic_probe_hash_table_top DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Reset is held from the start and then released for good.
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      for (int s = 0; s < TABLE_SLOTS; s++) begin
         tbl_used[s] = 1'b0;
      end
   end

   // Slot visited by a given probe number, probe 0 being the home slot. Odd probes go
   // below the home slot by c*c, even probes above it. The slot index type is exactly
   // as wide as the table, so truncation does the wrap.
   function automatic slot_idx_type probe_at(input slot_idx_type home, input int unsigned probe_no);
      int unsigned  c;
      slot_idx_type off;
      c   = probe_no >> 1;
      off = slot_idx_type'(c * c);
      return probe_no[0] ? slot_idx_type'(home - off) : slot_idx_type'(home + off);
   endfunction

   // Applies one request to the table image and returns the answer it must give.
   function automatic rsp_item_type table_apply(input req_item_type r);
      rsp_item_type res;
      slot_idx_type home;
      slot_idx_type pos;
      bit           stop;
      res  = '0;
      home = r.key_hash[IDX_W-1:0];
      stop = 1'b0;
      case (r.req_type)
         REQ_CLEAR: begin
            for (int s = 0; s < TABLE_SLOTS; s++) begin
               tbl_used[s] = 1'b0;
            end
         end
         REQ_INSERT: begin
            // First empty slot on the path wins; duplicates are not looked for.
            for (int unsigned p = 0; p <= PROBE_LIMIT && !stop; p++) begin
               pos = probe_at(home, p);
               if (!tbl_used[pos]) begin
                  tbl_used[pos]  = 1'b1;
                  tbl_key[pos]   = r.key_id;
                  tbl_value[pos] = r.value_word;
                  tbl_tag[pos]   = r.value_tag;
                  stop = 1'b1;
               end
            end
            // Every visited slot was taken: the table counts as full for this key.
            res.status = !stop;
         end
         REQ_LOOKUP: begin
            // An empty slot ends the search, as does the end of the probe limit.
            for (int unsigned p = 0; p <= PROBE_LIMIT && !stop; p++) begin
               pos = probe_at(home, p);
               if (!tbl_used[pos]) begin
                  stop = 1'b1;
               end else if (tbl_key[pos] == r.key_id) begin
                  res.found       = 1'b1;
                  res.found_value = tbl_value[pos];
                  res.found_tag   = tbl_tag[pos];
                  stop = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // Driver. A request stays on the bus until the block takes it. Between transfers it
   // waits out the gap of the next request, and a request flagged to drain waits until
   // every answer has come out. The counters live here only, so the drain decision does
   // not depend on the order in which the clocked blocks run.
   always @(posedge clock) begin
      bit handed;
      if (reset) begin
         start    <= 1'b0;
         req_data <= '0;
         gap_wait = 0;
      end else begin
         handed = start && !busy;
         if (handed) sent_count++;
         if (rsp_strobe) heard_count++;
         if (start && !handed) begin
            // Held off by busy; keep the same request on the bus.
         end else if (requests_waiting.size() != 0 && gap_wait < requests_waiting[0].gap) begin
            gap_wait++;
            start <= 1'b0;
         end else if (requests_waiting.size() != 0 && requests_waiting[0].drain &&
                      sent_count != heard_count) begin
            start <= 1'b0;
         end else if (requests_waiting.size() != 0) begin
            req_data <= requests_waiting[0].item;
            start    <= 1'b1;
            requests_waiting.pop_front();
            gap_wait = 0;
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
      end
   endtask

   // Monitor. A result shown on the strobe is taken at the edge that ends its cycle and
   // checked against the oldest expected answer. The same block predicts the answer of
   // every request transfer seen at this edge, so the store never sees a push and a pop
   // in an order that the simulator chooses.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (answers_due.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t ns: result with none expected, got %h", $time, rsp_data);
            end else begin
               want = answers_due.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_data.status));
               check_field("found", 64'(want.found), 64'(rsp_data.found));
               check_field("found_value", want.found_value, rsp_data.found_value);
               check_field("found_tag", 64'(want.found_tag), 64'(rsp_data.found_tag));
            end
         end
         if (start && !busy)
            answers_due.push_back(table_apply(req_data));
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Mostly back-to-back or short gaps, now and then a long one; quiet stretches have none.
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (quiet_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(30, 150);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic add_req(input logic [1:0] kind, input logic [31:0] key, input logic [31:0] hash,
                          input logic [63:0] value, input logic [3:0] tag);
      queued_req_type q;
      q.item.req_type   = kind;
      q.item.key_id     = key;
      q.item.key_hash   = hash;
      q.item.value_word = value;
      q.item.value_tag  = tag;
      q.gap   = pick_gap();
      q.drain = drain_next;
      drain_next = 1'b0;
      requests_waiting.push_back(q);
      if (kind != REQ_UNUSED) counted_items++;
   endtask

   // Stimulus and end of run.
   initial begin
      logic [31:0]  pool_key[128];
      logic [31:0]  pool_hash[128];
      slot_idx_type home;
      int unsigned  n;
      int unsigned  j;
      int unsigned  r;
      bit           first_episode;

      // Directed part. Home slot 0 and home slot 255 sit next to each other through the
      // wrap, so the early probes below zero run into the all-ones entry.
      add_req(REQ_LOOKUP, 32'h0, 32'h0, '0, '0);                       // miss on an empty table
      add_req(REQ_INSERT, '1, '1, '1, '1);                             // all ones
      add_req(REQ_LOOKUP, '1, '1, '0, '0);                             // hit at home
      add_req(REQ_INSERT, 32'h0, 32'h0, '0, 4'h0);                     // zero tag, zero value
      add_req(REQ_LOOKUP, 32'h0, 32'h0, '1, '1);                       // zero tag still found
      add_req(REQ_INSERT, 32'h1, 32'h100, 64'h0123_4567_89AB_CDEF, 4'h3);
      add_req(REQ_INSERT, 32'h2, 32'h200, 64'hFEDC_BA98_7654_3210, 4'h7);
      add_req(REQ_INSERT, 32'h3, 32'hFFFF_FF00, 64'h5555_5555_5555_5555, 4'h5);
      add_req(REQ_LOOKUP, 32'h3, 32'h0000_0300, '0, '0);               // hit several probes deep
      add_req(REQ_LOOKUP, 32'h4, 32'h0, '0, '0);                       // miss at an empty slot
      add_req(REQ_INSERT, 32'h1, 32'h100, 64'hAAAA_AAAA_AAAA_AAAA, 4'hA); // duplicate key
      add_req(REQ_LOOKUP, 32'h1, 32'h100, '0, '0);                     // first copy answers
      add_req(REQ_UNUSED, '1, '1, '1, '1);                             // ignored request code
      add_req(REQ_LOOKUP, '1, 32'h0000_00FF, '0, '0);                  // table unchanged
      add_req(REQ_LOOKUP, 32'h2, 32'h0, '0, '0);
      add_req(REQ_CLEAR, '1, '1, '1, '1);
      add_req(REQ_LOOKUP, '1, '1, '0, '0);                             // miss after clear
      add_req(REQ_INSERT, 32'h5555_5555, 32'hAAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 4'hA);
      add_req(REQ_LOOKUP, 32'h5555_5555, 32'h0000_00AA, '0, '0);
      add_req(REQ_LOOKUP, 32'hAAAA_AAAA, 32'hAAAA_AAAA, '0, '0);      // same home, other key
      add_req(REQ_CLEAR, '0, '0, '0, '0);

      // Random part, in episodes. Cluster episodes pile many keys onto one home slot so
      // that probes go deep, and the large ones exhaust the probe path so that inserts
      // report the table full and lookups run to the probe limit. Noise episodes mix
      // every request code over a few keys near each other.
      counted_items = 0;
      first_episode = 1'b1;
      while (counted_items < RANDOM_ITEMS) begin
         quiet_mode = ($urandom_range(0, 5) == 0);
         drain_next = first_episode || ($urandom_range(0, 2) == 0);
         r = $urandom_range(0, 9);
         if (r < 6 || first_episode) begin
            if ($urandom_range(0, 2) == 0 || first_episode)
               add_req(REQ_CLEAR, $urandom, $urandom, rand64(), 4'($urandom));
            home = slot_idx_type'($urandom);
            if (first_episode || $urandom_range(0, 3) == 0)
               n = $urandom_range(80, 110);
            else
               n = $urandom_range(2, 20);
            for (int unsigned i = 0; i < n; i++) begin
               if (i > 0 && $urandom_range(0, 9) == 0) begin
                  j = $urandom_range(0, i - 1);
                  pool_key[i]  = pool_key[j];
                  pool_hash[i] = pool_hash[j];
               end else begin
                  pool_key[i]  = $urandom;
                  pool_hash[i] = {$urandom} & ~32'(TABLE_SLOTS - 1);
                  if ($urandom_range(0, 4) == 0)
                     pool_hash[i] = pool_hash[i] |
                                    32'(slot_idx_type'(home + $urandom_range(0, 3)));
                  else
                     pool_hash[i] = pool_hash[i] | 32'(home);
               end
               add_req(REQ_INSERT, pool_key[i], pool_hash[i], rand64(), 4'($urandom));
               if ($urandom_range(0, 4) == 0) begin
                  j = $urandom_range(0, i);
                  add_req(REQ_LOOKUP, pool_key[j], pool_hash[j], rand64(), 4'($urandom));
               end
               if ($urandom_range(0, 19) == 0)
                  add_req(REQ_UNUSED, $urandom, $urandom, rand64(), 4'($urandom));
            end
            for (int unsigned i = 0; i < n / 2 + 3; i++) begin
               if ($urandom_range(0, 3) != 0) begin
                  j = $urandom_range(0, n - 1);
                  add_req(REQ_LOOKUP, pool_key[j], pool_hash[j], rand64(), 4'($urandom));
               end else begin
                  add_req(REQ_LOOKUP, $urandom, ({$urandom} & ~32'(TABLE_SLOTS - 1)) | 32'(home),
                          rand64(), 4'($urandom));
               end
            end
         end else begin
            for (int unsigned i = 0; i < 6; i++) begin
               pool_key[i]  = $urandom;
               pool_hash[i] = ({$urandom} & ~32'h7) | 32'($urandom_range(0, 7));
            end
            n = $urandom_range(15, 30);
            for (int unsigned i = 0; i < n; i++) begin
               j = $urandom_range(0, 5);
               r = $urandom_range(0, 99);
               if (r < 45)
                  add_req(REQ_INSERT, pool_key[j], pool_hash[j], rand64(), 4'($urandom));
               else if (r < 90)
                  add_req(REQ_LOOKUP, pool_key[j], pool_hash[j], rand64(), 4'($urandom));
               else if (r < 93)
                  add_req(REQ_CLEAR, $urandom, $urandom, rand64(), 4'($urandom));
               else
                  add_req(REQ_UNUSED, $urandom, $urandom, rand64(), 4'($urandom));
            end
         end
         first_episode = 1'b0;
      end

      // Wait until every request has been transferred and answered. Sampling on the
      // falling edge sees the driver's counters after the rising edge has settled.
      do begin
         @(negedge clock);
      end while (requests_waiting.size() != 0 || start || sent_count != heard_count);

      // Let the deepest probe time pass so that a stray late result would still be caught.
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (error_count == 0 && answers_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
